// ===== src/sfpd_pkg.sv =====
// Shared constants, register codes and transaction types of the feedback peak detector.
`timescale 1ns / 1ps

package sfpd_pkg;

    // Geometry
    localparam int NUM_BINS  = 513;
    localparam int MAG_W     = 24;
    localparam int BIN_W     = 10;
    localparam int HALF_SPAN = 5;
    localparam int WIN_LEN   = 2 * HALF_SPAN + 1;

    // Derived widths
    localparam int CNT_W   = $clog2(WIN_LEN);
    localparam int SUM_W   = MAG_W + CNT_W;
    localparam int DRN_W   = $clog2(HALF_SPAN + 1);
    localparam int PST_W   = 8;
    localparam int PST_AW  = $clog2(NUM_BINS);
    localparam int FILL_W  = $clog2(NUM_BINS + 1);
    localparam int RATIO_W = 16;
    localparam int Q_SHIFT = 8;
    localparam int MC_W    = MAG_W + CNT_W;
    localparam int LHS_W   = MC_W + Q_SHIFT;
    localparam int PROD_W  = RATIO_W + SUM_W;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register reset values
    localparam logic [BIN_W-1:0]   LOWEST_RST  = 10'd5;
    localparam logic [BIN_W-1:0]   HIGHEST_RST = 10'd170;
    localparam logic [RATIO_W-1:0] RATIO_RST   = 16'd512;
    localparam logic [PST_W-1:0]   CONFIRM_RST = 8'd3;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_LOWEST_BIN,
        REG_HIGHEST_BIN,
        REG_RATIO,
        REG_CONFIRM
    } t_reg_idx;

    // One bin ready for the threshold test, taken from the window center
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             peak;
        logic             last;
    } t_token;

    // One result transaction
    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [MAG_W-1:0] bin_magnitude;
        logic [PST_W-1:0] persistence;
        logic             local_peak;
        logic             confirmed;
        logic             newly_confirmed;
        logic             last_of_frame;
    } t_result;

endpackage

// ===== src/sfpd_ifs.sv =====
// Valid/ready channel interfaces for bin input and result output.
`timescale 1ns / 1ps

interface sfpd_bin_if;
    import sfpd_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude;
    logic             frame_end;

    modport source (output valid, output magnitude, output frame_end, input ready);
    modport sink   (input valid, input magnitude, input frame_end, output ready);
endinterface

interface sfpd_res_if;
    import sfpd_pkg::*;

    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] bin_index;
    logic [MAG_W-1:0] bin_magnitude;
    logic [PST_W-1:0] persistence;
    logic             local_peak;
    logic             confirmed;
    logic             newly_confirmed;
    logic             last_of_frame;

    modport source (
        output valid, output bin_index, output bin_magnitude, output persistence,
        output local_peak, output confirmed, output newly_confirmed,
        output last_of_frame, input ready
    );
    modport sink (
        input valid, input bin_index, input bin_magnitude, input persistence,
        input local_peak, input confirmed, input newly_confirmed,
        input last_of_frame, output ready
    );
endinterface

// ===== src/sfpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sfpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sfpd_window.sv =====
// Eleven-bin magnitude window: shift line, surround sum, frame drain and center token.
`timescale 1ns / 1ps

module sfpd_window (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [sfpd_pkg::MAG_W-1:0] i_magnitude,
    input  logic                   i_frame_end,
    output logic                   o_tok_valid,
    input  logic                   i_tok_ready,
    output sfpd_pkg::t_token       o_tok
);
    import sfpd_pkg::*;

    logic [MAG_W-1:0]   r_tap [WIN_LEN];
    logic [MAG_W-1:0]   n_tap [WIN_LEN];
    logic [WIN_LEN-1:0] r_vld, n_vld;
    logic [SUM_W-1:0]   r_tot, n_tot;
    logic [BIN_W-1:0]   r_next, n_next;
    logic [BIN_W-1:0]   r_ctr, n_ctr;
    logic [DRN_W-1:0]   r_drain, n_drain;
    logic               r_done, n_done;

    logic             pend, free, accept, hole, shift, fin, new_frame;
    logic [MAG_W-1:0] in_mag, drop;
    logic [CNT_W-1:0] count;

    // Handshake: center tap must be issued before the line moves
    always_comb begin
        pend      = r_vld[HALF_SPAN] && !r_done;
        free      = !pend || i_tok_ready;
        o_ready   = (r_drain == '0) && free;
        accept    = i_valid && o_ready;
        hole      = (r_drain != '0) && free;
        shift     = accept || hole;
        fin       = i_frame_end || (r_next >= BIN_W'(NUM_BINS - 1));
        new_frame = accept && (r_next == '0);
        in_mag    = accept ? i_magnitude : '0;
        drop      = r_vld[WIN_LEN-1] ? r_tap[WIN_LEN-1] : '0;
    end

    // Next state of the shift line and frame counters
    always_comb begin
        n_tap   = r_tap;
        n_vld   = r_vld;
        n_tot   = r_tot;
        n_ctr   = r_ctr;
        n_done  = r_done;
        n_next  = r_next;
        n_drain = r_drain;

        if (shift) begin
            n_tap[0] = in_mag;
            for (int k = 1; k < WIN_LEN; k++) begin
                n_tap[k] = r_tap[k-1];
            end
            if (new_frame) begin
                // bins of the previous frame leave the surround
                n_vld = {{(WIN_LEN-1){1'b0}}, 1'b1};
                n_tot = SUM_W'(i_magnitude);
            end else begin
                n_vld = {r_vld[WIN_LEN-2:0], accept};
                n_tot = r_tot + SUM_W'(in_mag) - SUM_W'(drop);
            end
            n_ctr  = r_vld[HALF_SPAN] ? r_ctr + BIN_W'(1) : '0;
            n_done = 1'b0;
        end else if (pend && i_tok_ready) begin
            n_done = 1'b1;
        end

        if (accept) begin
            n_next  = fin ? '0 : r_next + BIN_W'(1);
            n_drain = fin ? DRN_W'(HALF_SPAN) : '0;
        end else if (hole) begin
            n_drain = r_drain - DRN_W'(1);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_next  <= '0;
            r_drain <= '0;
            r_done  <= 1'b0;
        end else begin
            r_vld   <= n_vld;
            r_next  <= n_next;
            r_drain <= n_drain;
            r_done  <= n_done;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_tap <= n_tap;
        r_tot <= n_tot;
        r_ctr <= n_ctr;
    end

    // Number of surround bins inside the frame
    always_comb begin
        count = '0;
        for (int k = 0; k < WIN_LEN; k++) begin
            if (k != HALF_SPAN) begin
                count = count + CNT_W'(r_vld[k]);
            end
        end
    end

    // Center token; a missing neighbor skips its comparison
    always_comb begin
        o_tok_valid = pend;
        o_tok.bin   = r_ctr;
        o_tok.mag   = r_tap[HALF_SPAN];
        o_tok.sum   = r_tot - SUM_W'(r_tap[HALF_SPAN]);
        o_tok.count = count;
        o_tok.peak  = (!r_vld[HALF_SPAN+1] || (r_tap[HALF_SPAN] > r_tap[HALF_SPAN+1]))
                   && (!r_vld[HALF_SPAN-1] || (r_tap[HALF_SPAN] > r_tap[HALF_SPAN-1]));
        o_tok.last  = !r_vld[HALF_SPAN-1];
    end

endmodule

// ===== src/spectral_feedback_peak_detector.sv =====
// Top level of the spectral feedback peak detector: registers, test pipeline, persistence.
`timescale 1ns / 1ps

// Spectral feedback peak detector.
// i_bin takes one magnitude bin per transaction in bin order, frame_end on the
// last bin; a bin at index NUM_BINS-1 also ends the frame. o_res gives one
// result per bin, in bin order: persistence counter, peak and confirm flags.
// The APB port holds band limits, ratio threshold and confirm count; write it
// only while the block is idle. pready is tied high.
// Order: bin i reaches the window center once bin i+5 is accepted, then
// passes stage 1, stage 2 and the output register; the last bins of a frame
// follow the closing bin. Rate: one bin per cycle inside a frame while the
// output is not stalled. After the closing bin the window drains (up to six
// results) with i_bin.ready low; the five-bin lookahead window sets this drain.
// Reset: window, counters and output go empty, registers return to defaults.
// The persistence store (513 x 8 RAM) needs no clearing pass: a fill count
// makes bins not yet written read as zero.
// Stall: the output register holds its result; the pipeline stages behind it
// keep taking bins until they are full, then i_bin.ready drops.
module spectral_feedback_peak_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sfpd_bin_if.sink                      i_bin,
    sfpd_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfpd_pkg::APB_AW-1:0]   paddr,
    input  logic [sfpd_pkg::APB_DW-1:0]   pwdata,
    output logic [sfpd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import sfpd_pkg::*;

    // Configuration registers
    logic [BIN_W-1:0]   r_lowest, r_highest;
    logic [RATIO_W-1:0] r_ratio;
    logic [PST_W-1:0]   r_confirm;
    logic               cfg_wr;
    t_reg_idx           reg_sel;

    // Window to pipeline
    logic   tok_valid, tok_ready;
    t_token tok;

    // Stage 1: products
    logic               r1_vld;
    t_token             r1;
    logic               ready1, ready2, ready3, adv1, adv2;
    logic               in_band;
    logic [PROD_W-1:0]  prod;
    logic [MC_W-1:0]    mc;

    // Stage 2: compare and persistence update
    logic               r2_vld;
    logic [BIN_W-1:0]   r2_bin;
    logic [MAG_W-1:0]   r2_mag;
    logic               r2_peak, r2_inband, r2_last;
    logic [MC_W-1:0]    r2_mc;
    logic [PROD_W-1:0]  r2_prod;
    logic [PST_W-1:0]   ram_rd, p_old, p_new;
    logic [PROD_W-1:0]  lhs;
    logic               fwd_hit, pass, fresh;

    // Store bookkeeping: last write and written prefix
    logic               r_wr_vld;
    logic [BIN_W-1:0]   r_wr_addr;
    logic [PST_W-1:0]   r_wr_data;
    logic [FILL_W-1:0]  r_fill;

    // Output register
    logic    r_out_vld;
    t_result r_out;

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= LOWEST_RST;
            r_highest <= HIGHEST_RST;
            r_ratio   <= RATIO_RST;
            r_confirm <= CONFIRM_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_LOWEST_BIN:  r_lowest  <= pwdata[BIN_W-1:0];
                REG_HIGHEST_BIN: r_highest <= pwdata[BIN_W-1:0];
                REG_RATIO:       r_ratio   <= pwdata[RATIO_W-1:0];
                REG_CONFIRM:     r_confirm <= pwdata[PST_W-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_LOWEST_BIN:  prdata = APB_DW'(r_lowest);
            REG_HIGHEST_BIN: prdata = APB_DW'(r_highest);
            REG_RATIO:       prdata = APB_DW'(r_ratio);
            REG_CONFIRM:     prdata = APB_DW'(r_confirm);
        endcase
    end

    // Window and lookahead
    sfpd_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_bin.valid),
        .o_ready     (i_bin.ready),
        .i_magnitude (i_bin.magnitude),
        .i_frame_end (i_bin.frame_end),
        .o_tok_valid (tok_valid),
        .i_tok_ready (tok_ready),
        .o_tok       (tok)
    );

    // Stage handshakes; empty stages let bubbles collapse
    assign ready3    = !r_out_vld || o_res.ready;
    assign ready2    = !r2_vld || ready3;
    assign ready1    = !r1_vld || ready2;
    assign tok_ready = ready1;
    assign adv1      = r1_vld && ready2;
    assign adv2      = r2_vld && ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (ready1) begin
            r1_vld <= tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r1 <= tok;
        end
    end

    // Stage 1: band check and both sides of the ratio test
    always_comb begin
        in_band = (r1.bin >= r_lowest) && (r1.bin <= r_highest);
        prod    = PROD_W'(r_ratio) * PROD_W'(r1.sum);
        mc      = MC_W'(r1.mag) * MC_W'(r1.count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (ready2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r2_bin    <= r1.bin;
            r2_mag    <= r1.mag;
            r2_peak   <= in_band && r1.peak;
            r2_inband <= in_band;
            r2_last   <= r1.last;
            r2_mc     <= mc;
            r2_prod   <= prod;
        end
    end

    // Persistence store, read as the bin enters stage 2
    sfpd_ram #(
        .WIDTH (PST_W),
        .DEPTH (NUM_BINS)
    ) u_pst_ram (
        .i_clk     (i_clk),
        .i_wr_en   (adv2),
        .i_wr_addr (PST_AW'(r2_bin)),
        .i_wr_data (p_new),
        .i_rd_en   (adv1),
        .i_rd_addr (PST_AW'(r1.bin)),
        .o_rd_data (ram_rd)
    );

    // Stage 2: forward the latest write, unwritten bins read as zero
    always_comb begin
        fwd_hit = r_wr_vld && (r_wr_addr == r2_bin);
        priority if (fwd_hit) begin
            p_old = r_wr_data;
        end else if (FILL_W'(r2_bin) < r_fill) begin
            p_old = ram_rd;
        end else begin
            p_old = '0;
        end

        lhs   = {{(PROD_W-LHS_W){1'b0}}, r2_mc, {Q_SHIFT{1'b0}}};
        pass  = r2_peak && (lhs > r2_prod);
        p_new = p_old;
        fresh = 1'b0;
        if (r2_inband) begin
            if (pass) begin
                // saturating count still counts as an increment
                if (p_old != '1) begin
                    p_new = p_old + PST_W'(1);
                end
                fresh = (p_new >= r_confirm);
            end else if (p_old != '0) begin
                p_new = p_old - PST_W'(1);
            end
        end else begin
            p_new = '0;
        end
    end

    // Write tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
            r_fill   <= '0;
        end else if (adv2) begin
            r_wr_vld <= 1'b1;
            if (FILL_W'(r2_bin) >= r_fill) begin
                r_fill <= FILL_W'(r2_bin) + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_wr_addr <= r2_bin;
            r_wr_data <= p_new;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ready3) begin
            r_out_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_out.bin_index       <= r2_bin;
            r_out.bin_magnitude   <= r2_mag;
            r_out.persistence     <= p_new;
            r_out.local_peak      <= r2_peak;
            r_out.confirmed       <= (p_new >= r_confirm);
            r_out.newly_confirmed <= fresh;
            r_out.last_of_frame   <= r2_last;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.bin_index       = r_out.bin_index;
    assign o_res.bin_magnitude   = r_out.bin_magnitude;
    assign o_res.persistence     = r_out.persistence;
    assign o_res.local_peak      = r_out.local_peak;
    assign o_res.confirmed       = r_out.confirmed;
    assign o_res.newly_confirmed = r_out.newly_confirmed;
    assign o_res.last_of_frame   = r_out.last_of_frame;

    // A fresh confirmation needs a peak and a count at the confirm level
    a_fresh_confirmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.newly_confirmed |-> r_out.confirmed && r_out.local_peak)
        else $error("newly confirmed result without peak or confirmation");

    // Written prefix of the store never runs past its depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(NUM_BINS))
        else $error("persistence fill count beyond store depth");

    // Closing bin starts the drain, which holds off the next bin
    a_drain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bin.valid && i_bin.ready && i_bin.frame_end |=> !i_bin.ready)
        else $error("bin accepted right after frame end");

endmodule

// ===== bench/spectral_feedback_peak_detector_tb.sv =====
// Self-checking testbench for the spectral feedback peak detector: directed and random frames.
`timescale 1ns / 1ps

module spectral_feedback_peak_detector_tb;
    import sfpd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 16;

    // Probe frame for the reset band: extremes, bit patterns, in-band peaks at bins 5, 7 and 9
    localparam logic [MAG_W-1:0] PROBE [12] = '{
        24'h000000, 24'hFFFFFF, 24'h000001, 24'h000000, 24'h000010, 24'hFFFFFF,
        24'h000002, 24'h7FFFFF, 24'h000000, 24'hAAAAAA, 24'h555555, 24'h000003
    };

    // Tracks band registers and per-bin persistence, predicts every result transaction
    class persistence_predictor;
        logic [BIN_W-1:0]   band_lo;
        logic [BIN_W-1:0]   band_hi;
        logic [RATIO_W-1:0] ratio;
        logic [PST_W-1:0]   confirm;
        logic [PST_W-1:0]   persist [NUM_BINS];
        logic [MAG_W-1:0]   window [WIN_LEN];
        int unsigned        next_bin;
        t_result            expected_results [$];
        int unsigned        mismatches;

        function new();
            band_lo    = LOWEST_RST;
            band_hi    = HIGHEST_RST;
            ratio      = RATIO_RST;
            confirm    = CONFIRM_RST;
            next_bin   = 0;
            mismatches = 0;
            foreach (persist[i]) persist[i] = '0;
            foreach (window[i]) window[i] = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_LOWEST_BIN:  band_lo = value[BIN_W-1:0];
                REG_HIGHEST_BIN: band_hi = value[BIN_W-1:0];
                REG_RATIO:       ratio   = value[RATIO_W-1:0];
                REG_CONFIRM:     confirm = value[PST_W-1:0];
                default: ;
            endcase
        endfunction

        // Peak and surround test for bin c, n being the newest bin of the frame
        function void score_bin(int unsigned c, int unsigned n, bit last);
            t_result           r;
            logic [MAG_W-1:0]  mag;
            longint unsigned   surround;
            longint unsigned   neighbors;
            int unsigned       lo;
            int unsigned       hi;
            int unsigned       p;
            bit                peak;
            bit                fresh;
            bit                pass;
            mag   = window[c % WIN_LEN];
            lo    = (c >= HALF_SPAN) ? c - HALF_SPAN : 0;
            hi    = (c + HALF_SPAN < n) ? c + HALF_SPAN : n;
            p     = persist[c];
            peak  = 1'b0;
            fresh = 1'b0;
            if ((c >= band_lo) && (c <= band_hi)) begin
                peak = 1'b1;
                // edge bins skip the missing neighbor
                if (c > 0 && mag <= window[(c - 1) % WIN_LEN]) peak = 1'b0;
                if (c < n && mag <= window[(c + 1) % WIN_LEN]) peak = 1'b0;
                surround  = 0;
                neighbors = 0;
                for (int unsigned j = lo; j <= hi; j++) begin
                    if (j != c) begin
                        surround += window[j % WIN_LEN];
                        neighbors++;
                    end
                end
                pass = peak && (longint'(mag) * neighbors * 256 > longint'(ratio) * surround);
                if (pass) begin
                    if (p < 255) p++;
                    fresh = (p >= confirm);
                end else if (p > 0) begin
                    p--;
                end
            end else begin
                p = 0;
            end
            persist[c] = p[PST_W-1:0];

            r.bin_index       = c[BIN_W-1:0];
            r.bin_magnitude   = mag;
            r.persistence     = p[PST_W-1:0];
            r.local_peak      = peak;
            r.confirmed       = (p >= confirm);
            r.newly_confirmed = fresh;
            r.last_of_frame   = last;
            expected_results.insert(expected_results.size(), r);
        endfunction

        // One accepted bin: emit the bin five back, or flush the tail on frame close
        function void note_bin(logic [MAG_W-1:0] mag, logic fe);
            int unsigned n;
            int unsigned c;
            n = next_bin;
            window[n % WIN_LEN] = mag;
            if (fe || (n >= NUM_BINS - 1)) begin
                c = (n >= HALF_SPAN) ? n - HALF_SPAN : 0;
                while (c <= n) begin
                    score_bin(c, n, c == n);
                    c++;
                end
                next_bin = 0;
            end else begin
                if (n >= HALF_SPAN) score_bin(n - HALF_SPAN, n, 1'b0);
                next_bin = n + 1;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bin %0d mag %h pst %0d",
                             got.bin_index, got.bin_magnitude, got.persistence);
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got.bin_index       !== want.bin_index     ||
                    got.bin_magnitude   !== want.bin_magnitude ||
                    got.persistence     !== want.persistence   ||
                    got.local_peak      !== want.local_peak    ||
                    got.confirmed       !== want.confirmed     ||
                    got.newly_confirmed !== want.newly_confirmed ||
                    got.last_of_frame   !== want.last_of_frame) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: bin %0d mag %h pst %0d pk %b cf %b new %b last %b",
                                 want.bin_index, want.bin_magnitude, want.persistence,
                                 want.local_peak, want.confirmed, want.newly_confirmed,
                                 want.last_of_frame);
                        $display("         got: bin %0d mag %h pst %0d pk %b cf %b new %b last %b",
                                 got.bin_index, got.bin_magnitude, got.persistence,
                                 got.local_peak, got.confirmed, got.newly_confirmed,
                                 got.last_of_frame);
                    end
                end
            end
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int unsigned         src_idle_pct;
    int unsigned         sink_idle_pct;
    int unsigned         stall_cycles;
    persistence_predictor sb;

    sfpd_bin_if bin_if ();
    sfpd_res_if res_if ();

    spectral_feedback_peak_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bin   (bin_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // Result sink backpressure
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Transaction monitor: check results, then record accepted bins; watchdog count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                sb.check_result(t_result'{res_if.bin_index, res_if.bin_magnitude,
                                          res_if.persistence, res_if.local_peak,
                                          res_if.confirmed, res_if.newly_confirmed,
                                          res_if.last_of_frame});
            if (bin_if.valid && bin_if.ready)
                sb.note_bin(bin_if.magnitude, bin_if.frame_end);
            if ((res_if.valid && res_if.ready) || (bin_if.valid && bin_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Watchdog
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("** spectral_feedback_peak_detector: FAILED **");
        $finish;
    end

    // One bin transaction; starts and returns at a falling edge, valid left high
    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic fe);
        while ($urandom_range(99) < src_idle_pct) begin
            bin_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        bin_if.valid     <= 1'b1;
        bin_if.magnitude <= mag;
        bin_if.frame_end <= fe;
        @(posedge i_clk);
        while (!bin_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup then access phase, then the bus idles before the task returns
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(negedge i_clk);
    endtask

    // Let the block drain, then load all four registers
    task automatic reconfigure(input int unsigned lo, input int unsigned hi,
                               input int unsigned ratio, input int unsigned confirm);
        bin_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        write_reg(REG_LOWEST_BIN, lo);
        write_reg(REG_HIGHEST_BIN, hi);
        write_reg(REG_RATIO, ratio);
        write_reg(REG_CONFIRM, confirm);
    endtask

    // Repeated spectra with a low floor and a few tall peaks, plus noise and cut frames
    task automatic run_spectra(input int unsigned budget, input int unsigned max_len);
        logic [MAG_W-1:0] shape [$];
        logic [MAG_W-1:0] mag;
        int unsigned      sent;
        int unsigned      len;
        int unsigned      cut;
        bit               noisy;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 5) : $urandom_range(6, max_len);
            shape.delete();
            repeat (len) shape.insert(shape.size(), MAG_W'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 3))
                shape[$urandom_range(0, len - 1)] = MAG_W'($urandom_range(24'h001000, 24'hFFFFFF));
            // stop repeating the shape once the budget is spent
            repeat ($urandom_range(2, 6)) begin
                if (sent < budget) begin
                    noisy = ($urandom_range(5) == 0);
                    cut   = ($urandom_range(7) == 0) ? $urandom_range(1, len) : len;
                    for (int unsigned i = 0; i < cut; i++) begin
                        mag = noisy ? MAG_W'($urandom) : shape[i] + MAG_W'($urandom_range(0, 63));
                        send_bin(mag, i == cut - 1);
                    end
                    sent += cut;
                end
            end
        end
    endtask

    initial begin
        logic [MAG_W-1:0] top;
        sb               = new();
        stall_cycles     = 0;
        src_idle_pct     = 22;
        sink_idle_pct    = 54;
        i_rst_n          = 1'b0;
        bin_if.valid     = 1'b0;
        bin_if.magnitude = '0;
        bin_if.frame_end = 1'b0;
        res_if.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset band: bins below lowest_bin are out of band
        for (int i = 0; i < 12; i++) send_bin(PROBE[i], i == 11);

        // Full band, zero ratio, zero confirm count
        reconfigure(0, NUM_BINS - 1, 0, 0);
        send_bin(24'hFFFFFF, 1'b1);                 // single-bin frame
        send_bin(24'h000400, 1'b0);                 // first bin, surround sum of one
        send_bin(24'h000000, 1'b0);
        send_bin(24'h000000, 1'b0);
        send_bin(24'h000000, 1'b0);
        send_bin(24'h000001, 1'b1);                 // last bin, no right neighbor
        send_bin(24'h000007, 1'b0);                 // equal pair, no strict maximum
        send_bin(24'h000007, 1'b1);

        // Empty band, highest ratio
        reconfigure(NUM_BINS - 1, 0, 16'hFFFF, 1);
        send_bin(24'h000000, 1'b0);
        send_bin(24'hFFFFFF, 1'b0);
        send_bin(24'h000000, 1'b0);
        send_bin(24'h123456, 1'b1);

        // Whole band at twice the surround average
        reconfigure(0, NUM_BINS - 1, 512, 3);
        run_spectra(45, 20);

        // Two-bin frames: bin 0 passes every time and climbs past the confirm level
        src_idle_pct  = 54;
        sink_idle_pct = 22;
        reconfigure(0, NUM_BINS - 1, 0, 12);
        repeat (20) begin
            top = MAG_W'($urandom_range(1, 24'hFFFFFF));
            send_bin(top, 1'b0);
            send_bin(MAG_W'($urandom_range(0, top - 1)), 1'b1);
        end

        reconfigure(3, 14, $urandom_range(256, 1024), $urandom_range(1, 6));
        run_spectra(40, 18);

        // No idling from here on
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        reconfigure(2, 40, 768, 2);
        run_spectra(35, 24);
        reconfigure(1, NUM_BINS - 1, $urandom_range(256, 2048), $urandom_range(1, 4));
        run_spectra(25, 16);

        // Drain and finish
        bin_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("** spectral_feedback_peak_detector: PASSED **");
        end else begin
            $display("** spectral_feedback_peak_detector: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sfpd_pkg.sv
src/sfpd_ifs.sv
src/sfpd_ram.sv
src/sfpd_window.sv
src/spectral_feedback_peak_detector.sv
bench/spectral_feedback_peak_detector_tb.sv
